// ----- rtl/mec_pkg.sv -----
// ----------------------------------------------------------------------------
// mec_pkg
// shared constants and helpers for the escape-time counter: register indexes,
// fixed point format and signed saturation
// ----------------------------------------------------------------------------
`default_nettype none

package mec_pkg;

  // q8.24 fixed point
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 2 * DATA_W;

  // configuration port
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 3'd4;

  // register reset values
  localparam logic signed [31:0] CENTER_X_RST    = 32'sd0;
  localparam logic signed [31:0] CENTER_Y_RST    = 32'sd0;
  localparam logic [30:0]        PIXEL_STEP_RST  = 31'd167772;
  localparam logic [30:0]        ESCAPE_LIM_RST  = 31'd167772160;
  localparam logic [7:0]         MAX_ITER_RST    = 8'd255;

  // payload widths
  localparam int unsigned PIX_W  = 10;
  localparam int unsigned ITER_W = 8;

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // clamp a 64-bit signed value to the signed 32-bit range
  function automatic fix_t sat32(input prod_t v);
    fix_t r;
    if (v[PROD_W-1:DATA_W-1] != {(DATA_W+1){v[PROD_W-1]}}) begin
      r = v[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mandelbrot_escape_count.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_count
// escape-time iteration count for one pixel, signed q8.24 fixed point
// ----------------------------------------------------------------------------
// usage
//   input stream: one beat per pixel, tdata carries pixel_col and pixel_row.
//   the pixel maps to c = ((col - w/2)*step + center_x, (row - h/2)*step +
//   center_y), then z = c is iterated as z = z^2 + c until |z|^2 exceeds the
//   escape limit or max_iterations passes are done.
//   output stream: one beat per pixel, tdata carries iter_count.
//   config port: write enable, register index and data; the user must write
//   it only while the block is idle, the block does not enforce this.
//   registers: center_x, center_y, pixel_step, escape_limit_sq, max_iterations.
// timing
//   all multiplies go through one 32x32 signed multiplier with a registered
//   product. mapping runs col offset * step, row offset * step, then z = c;
//   each pass runs x*x, y*y, x*y with the escape compare, then the z update.
//   input reopens in the same cycle that a count appears in the output
//   register.
// reset and stall
//   reset loads the register defaults and empties the output register.
//   a new pixel is taken while a finished result still waits downstream;
//   the next result then holds in its final state until the output frees.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_count #(
  parameter int unsigned FRAME_WIDTH  = 800,
  parameter int unsigned FRAME_HEIGHT = 600
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration writes
  input  wire logic                             cfg_we_i,
  input  wire logic [mec_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mec_pkg::DATA_W-1:0]       cfg_wdata_i,
  // pixel stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [23:0]                      s_axis_tdata,   // pixel_col, pixel_row, pad
  // count stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [7:0]                            m_axis_tdata    // iter_count
);

  import mec_pkg::*;

  // half frame sizes and the width of a signed pixel offset
  localparam int unsigned HALF_X = FRAME_WIDTH / 2;
  localparam int unsigned HALF_Y = FRAME_HEIGHT / 2;
  localparam int unsigned HALF_MAX = (HALF_X > HALF_Y) ? HALF_X : HALF_Y;
  localparam int unsigned HALF_W = $clog2(HALF_MAX + 1);
  localparam int unsigned MAG_W  = (HALF_W > PIX_W) ? HALF_W : PIX_W;
  localparam int unsigned OFF_W  = MAG_W + 1;

  localparam logic [MAG_W-1:0] HALF_X_C = MAG_W'(HALF_X);
  localparam logic [MAG_W-1:0] HALF_Y_C = MAG_W'(HALF_Y);

  // sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MAPX = 4'd1;   // col offset * step
  localparam logic [3:0] ST_MAPY = 4'd2;   // cx from product, row offset * step
  localparam logic [3:0] ST_MAPZ = 4'd3;   // cy from product, z = c
  localparam logic [3:0] ST_SQX  = 4'd4;   // cap check, x*x
  localparam logic [3:0] ST_SQY  = 4'd5;   // y*y
  localparam logic [3:0] ST_XY   = 4'd6;   // escape compare, x*y
  localparam logic [3:0] ST_UPD  = 4'd7;   // z = z^2 + c
  localparam logic [3:0] ST_DONE = 4'd8;   // hand off to output register

  // configuration registers
  fix_t              center_x_q, center_y_q;
  logic [30:0]       step_q, esc_lim_q;
  logic [ITER_W-1:0] max_iter_q;

  // datapath registers
  logic [3:0]        state_q, state_d;
  logic [PIX_W-1:0]  col_q, row_q;
  fix_t              cx_q, cy_q, zx_q, zy_q;
  prod_t             prod_q, x2_q, diff_q;
  logic [ITER_W-1:0] n_q;
  logic              out_valid_q;
  logic [ITER_W-1:0] out_q;

  // shared multiplier
  fix_t              mul_a, mul_b;
  prod_t             prod_d;

  logic signed [OFF_W-1:0] off_x, off_y;
  logic [PROD_W-1:0]       r2, limit;
  logic                    escaped;
  logic                    in_beat, out_load;
  prod_t                   map_x_sum, map_y_sum, upd_x_sum, upd_y_sum;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      step_q     <= PIXEL_STEP_RST;
      esc_lim_q  <= ESCAPE_LIM_RST;
      max_iter_q <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X:   center_x_q <= cfg_wdata_i;
        CFG_CENTER_Y:   center_y_q <= cfg_wdata_i;
        CFG_PIXEL_STEP: step_q     <= cfg_wdata_i[30:0];
        CFG_ESCAPE_LIM: esc_lim_q  <= cfg_wdata_i[30:0];
        CFG_MAX_ITER:   max_iter_q <= cfg_wdata_i[ITER_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // combinational datapath
  // ---------------------------------------------------------------------------
  assign off_x = $signed({1'b0, MAG_W'(col_q)}) - $signed({1'b0, HALF_X_C});
  assign off_y = $signed({1'b0, MAG_W'(row_q)}) - $signed({1'b0, HALF_Y_C});

  // operand select for the one multiplier
  always_comb begin
    unique case (state_q)
      ST_MAPX: begin
        mul_a = {{(DATA_W-OFF_W){off_x[OFF_W-1]}}, off_x};
        mul_b = {1'b0, step_q};
      end
      ST_MAPY: begin
        mul_a = {{(DATA_W-OFF_W){off_y[OFF_W-1]}}, off_y};
        mul_b = {1'b0, step_q};
      end
      ST_SQX: begin
        mul_a = zx_q;
        mul_b = zx_q;
      end
      ST_SQY: begin
        mul_a = zy_q;
        mul_b = zy_q;
      end
      default: begin
        mul_a = zx_q;
        mul_b = zy_q;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // squares are non-negative and at most 2^62, so the sum cannot wrap
  assign r2      = $unsigned(x2_q) + $unsigned(prod_q);
  assign limit   = {9'd0, esc_lim_q, FRAC_BITS'(0)};
  assign escaped = r2 > limit;

  assign map_x_sum = prod_q + prod_t'(center_x_q);
  assign map_y_sum = prod_q + prod_t'(center_y_q);
  // arithmetic shifts round toward minus infinity
  assign upd_x_sum = (diff_q >>> FRAC_BITS) + prod_t'(cx_q);
  assign upd_y_sum = (prod_q >>> (FRAC_BITS - 1)) + prod_t'(cy_q);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_beat) state_d = ST_MAPX;
      ST_MAPX: state_d = ST_MAPY;
      ST_MAPY: state_d = ST_MAPZ;
      ST_MAPZ: state_d = ST_SQX;
      ST_SQX:  state_d = (n_q == max_iter_q) ? ST_DONE : ST_SQY;
      ST_SQY:  state_d = ST_XY;
      ST_XY:   state_d = escaped ? ST_DONE : ST_UPD;
      ST_UPD:  state_d = ST_SQX;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_beat) begin
      col_q <= s_axis_tdata[PIX_W-1:0];
      row_q <= s_axis_tdata[2*PIX_W-1:PIX_W];
    end
    unique case (state_q)
      ST_MAPY: cx_q <= sat32(map_x_sum);
      ST_MAPZ: begin
        cy_q <= sat32(map_y_sum);
        zx_q <= cx_q;
        zy_q <= sat32(map_y_sum);
        n_q  <= '0;
      end
      ST_SQY:  x2_q   <= prod_q;
      ST_XY:   diff_q <= x2_q - prod_q;
      ST_UPD: begin
        zx_q <= sat32(upd_x_sum);
        zy_q <= sat32(upd_y_sum);
        n_q  <= n_q + ITER_W'(1);
      end
      default: ;
    endcase
    if (out_load) out_q <= n_q;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  // pass count stays within the cap while iterating
  a_iter_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQX || state_q == ST_SQY || state_q == ST_XY ||
     state_q == ST_UPD) |-> (n_q <= max_iter_q))
    else $error("iteration count beyond cap");

  // a delivered count never exceeds the cap
  a_out_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata <= max_iter_q))
    else $error("result beyond cap");

  // an accepted pixel starts the mapping
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == ST_MAPX))
    else $error("pixel accepted without starting");

  // a new result only comes out of the final state
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result without finished pixel");
`endif

endmodule

`default_nettype wire

// ----- verif/mandelbrot_escape_count_tb.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_count_tb
// self-checking bench for the escape-time counter: a directed table of pixels
// under a handful of fixed views, then random views with random pixels, every
// count checked in order against a typed count or the fixed point predictor in the bench
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_count_tb;

  import mec_pkg::*;

  // frame geometry, same as the block's defaults
  localparam int     FRAME_W = 800;
  localparam int     FRAME_H = 600;
  localparam longint HALF_W  = FRAME_W / 2;
  localparam longint HALF_H  = FRAME_H / 2;

  localparam longint FIX_MAX = 64'sd2147483647;
  localparam longint FIX_MIN = -64'sd2147483648;

  localparam int N_PROBES     = 26;
  localparam int N_VIEWS      = 7;
  localparam int RANDOM_ITEMS = 1030;
  localparam int HOLD_CYCLES  = 3000;  // long downstream stall for back pressure
  localparam int END_WAIT     = 1100;  // a little more than the slowest pixel
  localparam int TIMEOUT      = 12_000_000;

  // one full register setting
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        step;
    logic [30:0]        limit;
    logic [7:0]         cap;
  } view_t;

  // a row of the directed table; count is only used where typed is set
  typedef struct packed {
    logic [2:0]       view;
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic             typed;
    logic [ITER_W-1:0] count;
  } probe_t;

  typedef struct packed {
    logic              typed;
    logic [ITER_W-1:0] count;
  } count_hint_t;

  typedef struct packed {
    logic [PIX_W-1:0]  col;
    logic [PIX_W-1:0]  row;
    logic [ITER_W-1:0] count;
  } pixel_count_t;

  // block ports, all inputs known from time zero
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_CENTER_X;
  logic [DATA_W-1:0]    cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata  = '0;   // pixel_col, pixel_row, pad
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;         // iter_count

  // registers as the block should hold them right now
  view_t        active_view;
  view_t        views [N_VIEWS];
  probe_t       probes [N_PROBES];

  // counts still owed by the block, oldest first
  pixel_count_t pending_counts [$];
  // typed-in expectations, one per pixel handed to the sender
  count_hint_t  typed_q [$];

  int unsigned  mismatches = 0;
  int unsigned  burst_left = 0;
  bit           hold_req   = 1'b0;

  mandelbrot_escape_count dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp32(input longint v);
    longint r;
    if (v > FIX_MAX) begin
      r = FIX_MAX;
    end else if (v < FIX_MIN) begin
      r = FIX_MIN;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // escape-time count of one pixel under active_view
  function automatic logic [ITER_W-1:0] escape_count(input logic [PIX_W-1:0] col,
                                                     input logic [PIX_W-1:0] row);
    longint            cx, cy, zx, zy, x2, y2, xy;
    longint unsigned   r2, bound;
    logic [ITER_W-1:0] n;
    bit                escaped;
    // pixel to complex point, no check against the frame size
    cx = clamp32((longint'(col) - HALF_W) * longint'(active_view.step)
                 + longint'($signed(active_view.cx)));
    cy = clamp32((longint'(row) - HALF_H) * longint'(active_view.step)
                 + longint'($signed(active_view.cy)));
    zx = cx;
    zy = cy;
    // threshold moved up to the q16.48 scale of the squares
    bound = longint'(active_view.limit) << FRAC_BITS;
    n = '0;
    escaped = 1'b0;
    while (!escaped && n < active_view.cap) begin
      x2 = zx * zx;
      y2 = zy * zy;
      xy = zx * zy;
      r2 = $unsigned(x2) + $unsigned(y2);
      if (r2 > bound) begin
        escaped = 1'b1;
      end else begin
        // arithmetic shifts floor toward minus infinity; xy doubles via the shorter shift
        zx = clamp32(((x2 - y2) >>> FRAC_BITS) + cx);
        zy = clamp32((xy >>> (FRAC_BITS - 1)) + cy);
        n++;
      end
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // sample both streams at the rising edge; outputs first, since a count beat
  // always belongs to a pixel taken at an earlier edge
  always @(posedge clk_i) begin : scoreboard
    pixel_count_t e;
    count_hint_t  h;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_counts.size() == 0) begin
          report_mismatch($sformatf("iter_count beat %0d with no pixel waiting",
                                    m_axis_tdata));
        end else begin
          e = pending_counts.pop_front();
          if (m_axis_tdata !== e.count) begin
            report_mismatch($sformatf("pixel (%0d,%0d): iter_count %0d, expected %0d",
                                      e.col, e.row, m_axis_tdata, e.count));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        e.col = s_axis_tdata[PIX_W-1:0];
        e.row = s_axis_tdata[2*PIX_W-1:PIX_W];
        h = typed_q.pop_front();
        e.count = h.typed ? h.count : escape_count(e.col, e.row);
        pending_counts.push_back(e);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // count side: ready follows a pattern of its own, switching mode at random
  // intervals; a hold request drops ready for a long counted stretch
  // ---------------------------------------------------------------------------

  initial begin : ready_pattern
    int unsigned mode, mode_left, tick;
    mode = 0;
    mode_left = 200;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 512);
      end
      mode_left--;
      tick++;
      case (mode)
        0: begin
          m_axis_tready <= 1'b1;                          // no stalls
        end
        1: begin
          m_axis_tready <= 1'($urandom_range(0, 1));      // coin flip
        end
        2: begin
          m_axis_tready <= (tick % 5 == 0);               // one edge in five
        end
        default: begin
          m_axis_tready <= ($urandom_range(0, 7) == 0);   // mostly stalled
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pixel side and configuration
  // ---------------------------------------------------------------------------

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  // all five registers, one write per cycle, only while the block is idle
  task automatic write_view(input view_t v);
    put_reg(CFG_CENTER_X,   v.cx);
    put_reg(CFG_CENTER_Y,   v.cy);
    put_reg(CFG_PIXEL_STEP, {1'b0, v.step});
    put_reg(CFG_ESCAPE_LIM, {1'b0, v.limit});
    put_reg(CFG_MAX_ITER,   {24'd0, v.cap});
    cfg_we_i <= 1'b0;
    active_view = v;
  endtask

  // offer one pixel beat; the sender runs in bursts with random gaps between
  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
                            input count_hint_t h);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    typed_q.push_back(h);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
  endtask

  // stop offering and let every owed count come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic view_t random_view();
    view_t       v;
    int unsigned r;
    // center mostly around the set, sometimes anywhere
    r = $urandom_range(0, 9);
    v.cx = (r < 7) ? $urandom_range(0, 41943040) - 33554432 : $urandom();
    r = $urandom_range(0, 9);
    v.cy = (r < 7) ? $urandom_range(0, 41943040) - 20971520 : $urandom();
    r = $urandom_range(0, 9);
    if (r < 6) begin
      v.step = 31'($urandom_range(2000, 120000));
    end else if (r == 6) begin
      v.step = '0;                     // whole frame on the center
    end else if (r == 7) begin
      v.step = '1;
    end else begin
      v.step = 31'($urandom());
    end
    r = $urandom_range(0, 9);
    if (r < 6) begin
      v.limit = 31'($urandom_range(33554432, 167772160));   // 2.0 to 10.0
    end else if (r == 6) begin
      v.limit = '0;
    end else if (r == 7) begin
      v.limit = '1;
    end else begin
      v.limit = 31'($urandom());
    end
    // small caps keep most pixels short; a few phases run the full cap
    r = $urandom_range(0, 9);
    if (r < 8) begin
      v.cap = 8'($urandom_range(1, 40));
    end else if (r == 8) begin
      v.cap = '0;
    end else begin
      v.cap = '1;
    end
    return v;
  endfunction

  initial begin : stimulus
    int unsigned       cur, sent, phase, n;
    view_t             v;
    count_hint_t       h;
    logic [PIX_W-1:0]  col, row;

    //            cx             cy             step           limit          cap
    views = '{
      '{32'sh0000_0000, 32'sh0000_0000, 31'd167772,    31'h0a00_0000, 8'd255},  // reset
      '{32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff, 31'h0000_0000, 8'd0  },  // zero cap
      '{32'sh0000_0000, 32'sh0000_0000, 31'd0,         31'h0a00_0000, 8'd255},  // zero step
      '{32'sh0100_0000, 32'sh0000_0000, 31'd0,         31'h0000_0000, 8'd255},  // zero limit
      '{32'sh0000_0000, 32'sh0000_0000, 31'h7fff_ffff, 31'h7fff_ffff, 8'd255},  // huge step
      '{32'shff40_0000, 32'sh0019_999a, 31'd62914,     31'h0400_0000, 8'd1  },  // cap of one
      '{32'shff80_0000, 32'sh0000_0000, 31'd62914,     31'h0400_0000, 8'd30 }   // plain view
    };

    // view, col, row, typed, count
    probes = '{
      // reset view: the frame center is c = 0 and never escapes, corners escape at once
      '{3'd0, 10'd400,  10'd300,  1'b1, 8'd255},
      '{3'd0, 10'd0,    10'd0,    1'b1, 8'd0  },
      '{3'd0, 10'd799,  10'd599,  1'b1, 8'd0  },
      '{3'd0, 10'd1023, 10'd1023, 1'b1, 8'd0  },
      '{3'd0, 10'd0,    10'd1023, 1'b1, 8'd0  },
      '{3'd0, 10'd1023, 10'd0,    1'b1, 8'd0  },
      '{3'd0, 10'd400,  10'd0,    1'b0, 8'd0  },
      '{3'd0, 10'd200,  10'd300,  1'b0, 8'd0  },
      '{3'd0, 10'd300,  10'd320,  1'b0, 8'd0  },
      // zero cap: nothing iterates, even with saturating centers
      '{3'd1, 10'd0,    10'd0,    1'b1, 8'd0  },
      '{3'd1, 10'd1023, 10'd1023, 1'b1, 8'd0  },
      '{3'd1, 10'd400,  10'd300,  1'b1, 8'd0  },
      // zero step: every pixel sits on c = 0
      '{3'd2, 10'd0,    10'd0,    1'b1, 8'd255},
      '{3'd2, 10'd1023, 10'd1023, 1'b1, 8'd255},
      // zero limit with c = 1.0 escapes on the first test
      '{3'd3, 10'd0,    10'd0,    1'b1, 8'd0  },
      '{3'd3, 10'd400,  10'd300,  1'b1, 8'd0  },
      // largest step: off-center points saturate and escape, the center stays
      '{3'd4, 10'd400,  10'd300,  1'b1, 8'd255},
      '{3'd4, 10'd0,    10'd0,    1'b1, 8'd0  },
      '{3'd4, 10'd1023, 10'd1023, 1'b1, 8'd0  },
      '{3'd4, 10'd401,  10'd300,  1'b1, 8'd0  },
      '{3'd4, 10'd400,  10'd299,  1'b0, 8'd0  },
      '{3'd5, 10'd400,  10'd300,  1'b0, 8'd0  },
      '{3'd5, 10'd123,  10'd456,  1'b0, 8'd0  },
      '{3'd6, 10'd350,  10'd280,  1'b0, 8'd0  },
      '{3'd6, 10'd600,  10'd400,  1'b0, 8'd0  },
      '{3'd6, 10'd10,   10'd590,  1'b0, 8'd0  }
    };

    // the block comes out of reset holding the first view
    active_view = views[0];
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table, registers rewritten whenever the view changes
    cur = 0;
    for (int i = 0; i < N_PROBES; i++) begin
      if (probes[i].view != cur) begin
        wait_idle();
        cur = probes[i].view;
        write_view(views[cur]);
      end
      h.typed = probes[i].typed;
      h.count = probes[i].count;
      send_pixel(probes[i].col, probes[i].row, h);
    end

    // random views, each with a run of random pixels checked by the predictor
    sent = 0;
    phase = 0;
    h = '0;
    while (sent < RANDOM_ITEMS) begin
      v = random_view();
      // short pixels here so the stalled output backs up into the input quickly
      if (phase == 1) v.cap = 8'($urandom_range(1, 10));
      wait_idle();
      write_view(v);
      if (phase == 1) hold_req = 1'b1;
      n = (v.cap == 8'd255) ? 20 : 80;
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      repeat (n) begin
        // mostly inside the frame, now and then anywhere the field reaches
        if ($urandom_range(0, 7) == 0) begin
          col = PIX_W'($urandom_range(0, 1023));
          row = PIX_W'($urandom_range(0, 1023));
        end else begin
          col = PIX_W'($urandom_range(0, FRAME_W - 1));
          row = PIX_W'($urandom_range(0, FRAME_H - 1));
        end
        send_pixel(col, row, h);
        sent++;
      end
      phase++;
    end

    wait_idle();
    // catch any stray beat after the last count
    repeat (END_WAIT) @(negedge clk_i);
    if (pending_counts.size() != 0) begin
      report_mismatch($sformatf("%0d counts never came out", pending_counts.size()));
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #(TIMEOUT);
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
